// ===== rtl/core/convex_polygon_sat_collision_defines.svh =====
// assertion macros for the polygon separating-axis collision block
`ifndef CONVEX_POLYGON_SAT_COLLISION_DEFINES_SVH
`define CONVEX_POLYGON_SAT_COLLISION_DEFINES_SVH

// same-cycle implication
`define CPSAT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPSAT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cpsat_pkg.sv =====
// shared types, constants and helpers of the polygon collision block
package cpsat_pkg;

   localparam int DEF_MAX_VERTICES = 16;
   localparam int MIN_VERTICES     = 3;
   localparam int SQRT_STEPS       = 32;
   localparam int DIV_STEPS        = 31;

   // command codes
   localparam logic [1:0] CMD_ADD_A = 2'd0;
   localparam logic [1:0] CMD_ADD_B = 2'd1;
   localparam logic [1:0] CMD_EVAL  = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_SHORT = 2'd1;
   localparam logic [1:0] STAT_DROP  = 2'd2;

   // polygon select
   localparam logic SIDE_A = 1'b0;
   localparam logic SIDE_B = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EDGE_P,
      ST_EDGE_I,
      ST_EDGE_D,
      ST_NORM,
      ST_PROJ_RD,
      ST_PROJ_X,
      ST_PROJ_Y,
      ST_PROJ_S,
      ST_OVL,
      ST_BEST,
      ST_CTR_AX,
      ST_CTR_AY,
      ST_CTR_AS,
      ST_CTR_BX,
      ST_CTR_BY,
      ST_CTR_BS,
      ST_PUSH_X,
      ST_PUSH_Y,
      ST_PUSH_S,
      ST_FINISH
   } sat_state_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_SHIFT,
      N_SQX,
      N_SQY,
      N_SQRT,
      N_DIVX,
      N_DIVY,
      N_DONE
   } norm_state_type;

   typedef struct packed {
      logic               start;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
   } norm_req_type;

   typedef struct packed {
      logic               done;
      logic               ok;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
   } norm_rsp_type;

   // signed push component with saturation to 32 bits
   function automatic logic signed [31:0] push_sat(input logic [34:0] mag, input logic neg);
      logic signed [31:0] res;
      if (neg) begin
         if (mag > 35'h080000000) res = 32'sh80000000;
         else res = -$signed(mag[31:0]);
      end else begin
         if (mag > 35'h07FFFFFFF) res = 32'sh7FFFFFFF;
         else res = $signed(mag[31:0]);
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/cpsat_if.sv =====
// valid/ready channel interfaces for vertex commands and collision results
interface cpsat_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] vertex_x;
   logic signed [31:0] vertex_y;

   modport source(output valid, command, vertex_x, vertex_y, input ready);
   modport sink(input valid, command, vertex_x, vertex_y, output ready);
endinterface

interface cpsat_rsp_if;
   logic               valid;
   logic               ready;
   logic               colliding;
   logic signed [31:0] push_x;
   logic signed [31:0] push_y;
   logic [1:0]         status;

   modport source(output valid, colliding, push_x, push_y, status, input ready);
   modport sink(input valid, colliding, push_x, push_y, status, output ready);
endinterface

// ===== rtl/core/cpsat_norm.sv =====
// iterative unit-axis builder: normalize, isqrt and two restoring divides
module cpsat_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  cpsat_pkg::norm_req_type nreq,
   output cpsat_pkg::norm_rsp_type nrsp
);
   import cpsat_pkg::*;

   norm_state_type     state_ff, state_in;
   logic [33:0]        ux_ff, uy_ff;
   logic               sx_ff, sy_ff, ok_ff;
   logic [63:0]        v_ff, r_ff, bit_ff;
   logic [31:0]        rem_ff;
   logic [29:0]        q_ff;
   logic [4:0]         cnt_ff;
   logic signed [31:0] ax_ff, ay_ff;

   logic [33:0] adx, ady, m;
   logic [30:0] sq_op;
   logic [61:0] sq;
   logic [63:0] trial, sub_a, sub_b, diff;
   logic        ge, in_bit;
   logic [32:0] rem_sh;
   logic [30:0] quo;

   // magnitudes of the incoming direction
   assign adx = nreq.dx[33] ? 34'(-nreq.dx) : 34'(nreq.dx);
   assign ady = nreq.dy[33] ? 34'(-nreq.dy) : 34'(nreq.dy);
   assign m   = (ux_ff > uy_ff) ? ux_ff : uy_ff;

   // squaring multiplier, used once per component
   assign sq_op = (state_ff == N_SQX) ? ux_ff[30:0] : uy_ff[30:0];
   assign sq    = sq_op * sq_op;

   // shared compare/subtract unit for root and divide steps
   assign trial  = r_ff + bit_ff;
   assign in_bit = (cnt_ff == 5'd0) ? ((state_ff == N_DIVX) ? ux_ff[0] : uy_ff[0]) : 1'b0;
   assign rem_sh = {rem_ff, in_bit};
   always_comb begin
      if (state_ff == N_SQRT) begin
         sub_a = v_ff;
         sub_b = trial;
      end else begin
         sub_a = 64'(rem_sh);
         sub_b = 64'(r_ff[31:0]);
      end
   end
   assign ge   = sub_a >= sub_b;
   assign diff = sub_a - sub_b;
   assign quo  = {q_ff, ge};

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= N_IDLE;
      else state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         N_IDLE: begin
            if (nreq.start) state_in = (adx == '0 && ady == '0) ? N_DONE : N_SHIFT;
         end
         N_SHIFT: begin
            if (m[33:31] == '0 && m[30]) state_in = N_SQX;
         end
         N_SQX: state_in = N_SQY;
         N_SQY: state_in = N_SQRT;
         N_SQRT: begin
            if (cnt_ff == 5'(SQRT_STEPS - 1)) state_in = N_DIVX;
         end
         N_DIVX: begin
            if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = N_DIVY;
         end
         N_DIVY: begin
            if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = N_DONE;
         end
         N_DONE: state_in = N_IDLE;
         default: state_in = N_IDLE;
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         N_IDLE: begin
            if (nreq.start) begin
               ux_ff <= adx;
               uy_ff <= ady;
               sx_ff <= nreq.dx[33];
               sy_ff <= nreq.dy[33];
               ok_ff <= !(adx == '0 && ady == '0);
            end
         end
         N_SHIFT: begin
            if (m[33:31] != '0) begin
               ux_ff <= ux_ff >> 1;
               uy_ff <= uy_ff >> 1;
            end else if (!m[30]) begin
               ux_ff <= ux_ff << 1;
               uy_ff <= uy_ff << 1;
            end
         end
         N_SQX: v_ff <= 64'(sq);
         N_SQY: begin
            v_ff   <= v_ff + 64'(sq);
            r_ff   <= '0;
            bit_ff <= 64'(1) << 62;
            cnt_ff <= '0;
         end
         N_SQRT: begin
            if (ge) begin
               v_ff <= diff;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
               rem_ff <= ux_ff[32:1];
               cnt_ff <= '0;
            end
         end
         N_DIVX, N_DIVY: begin
            rem_ff <= ge ? diff[31:0] : rem_sh[31:0];
            q_ff   <= {q_ff[28:0], ge};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               cnt_ff <= '0;
               if (state_ff == N_DIVX) begin
                  ax_ff  <= sx_ff ? -$signed(32'(quo)) : $signed(32'(quo));
                  rem_ff <= uy_ff[32:1];
               end else begin
                  ay_ff <= sy_ff ? -$signed(32'(quo)) : $signed(32'(quo));
               end
            end
         end
         default: ;
      endcase
   end

   assign nrsp.done = (state_ff == N_DONE);
   assign nrsp.ok   = ok_ff;
   assign nrsp.ax   = ax_ff;
   assign nrsp.ay   = ay_ff;

endmodule

// ===== rtl/core/convex_polygon_sat_collision.sv =====
// Vertex loads (commands 0, 1) and unknown commands are taken only while idle.
// Evaluate, per usable edge: two vertex reads, the axis unit (normalizing shifts, integer
// root, two restoring divides), a projection of every vertex of both polygons, the overlap;
// a zero-length edge is skipped; a separating axis stops the search early.
// Too few vertices gives a result with no edge evaluated; input is held off meanwhile.
// Synchronous reset clears counts, drop flag and control; vertex RAM is not cleared.
`include "convex_polygon_sat_collision_defines.svh"

module convex_polygon_sat_collision #(
   parameter int MAX_VERTICES = cpsat_pkg::DEF_MAX_VERTICES
) (
   input logic         clock,
   input logic         reset,
   cpsat_req_if.sink   req,
   cpsat_rsp_if.source rsp
);
   import cpsat_pkg::*;

   localparam int IDXW = $clog2(MAX_VERTICES);
   localparam int CNTW = $clog2(MAX_VERTICES + 1);
   localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_VERTICES);
   localparam logic [CNTW-1:0] MINC = CNTW'(MIN_VERTICES);

   sat_state_type state_ff, state_in;

   logic [CNTW-1:0] count_a_ff, count_b_ff;
   logic            dropped_ff;

   // bounding boxes, tracked as vertices arrive
   logic signed [31:0] a_min_x_ff, a_max_x_ff, a_min_y_ff, a_max_y_ff;
   logic signed [31:0] b_min_x_ff, b_max_x_ff, b_min_y_ff, b_max_y_ff;

   logic [63:0] mem_a [MAX_VERTICES];
   logic [63:0] mem_b [MAX_VERTICES];
   logic [IDXW-1:0] raddr;
   logic            rside;
   logic [63:0]     rdata_ff;

   logic signed [31:0] vp_x_ff, vp_y_ff;
   logic               eside_ff, pside_ff;
   logic [IDXW-1:0]    eidx_ff, pidx_ff;
   logic signed [63:0] al_ff, ah_ff, bl_ff, bh_ff;
   logic [63:0]        ov_ff, best_ff;
   logic               found_ff;
   logic signed [31:0] bax_ff, bay_ff;
   logic signed [66:0] mul_ff, acc_ff, ca_ff;
   logic               pos_ff;

   logic               res_coll_ff;
   logic signed [31:0] res_px_ff, res_py_ff;
   logic [1:0]         res_stat_ff;
   logic               rsp_valid_ff, rsp_coll_ff;
   logic signed [31:0] rsp_px_ff, rsp_py_ff;
   logic [1:0]         rsp_stat_ff;

   norm_req_type nreq;
   norm_rsp_type nrsp;

   logic               req_fire, rsp_free, short_cnt;
   logic [CNTW-1:0]    n_e, n_p, n_e_m1, e_next, p_next;
   logic [IDXW-1:0]    prev_idx;
   logic               last_e, last_p, last_all, advance_edge;
   logic signed [31:0] cur_x, cur_y;
   logic signed [32:0] ex, ey, sum_ax, sum_ay, sum_bx, sum_by;
   logic signed [34:0] op_a;
   logic signed [31:0] op_b;
   logic signed [66:0] prod, acc_sum;
   logic signed [63:0] dot;
   logic [63:0]        ov_in;
   logic               sep_in, best_upd, neg_x, neg_y;
   logic [33:0]        ov16;
   logic [31:0]        abs_bax, abs_bay;

   // axis builder
   cpsat_norm u_norm (
      .clock (clock),
      .reset (reset),
      .nreq  (nreq),
      .nrsp  (nrsp)
   );

   // handshake and loop bookkeeping
   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign short_cnt = (count_a_ff < MINC) || (count_b_ff < MINC);

   assign n_e      = (eside_ff == SIDE_B) ? count_b_ff : count_a_ff;
   assign n_p      = (pside_ff == SIDE_B) ? count_b_ff : count_a_ff;
   assign n_e_m1   = n_e - 1'b1;
   assign prev_idx = (eidx_ff == '0) ? n_e_m1[IDXW-1:0] : eidx_ff - 1'b1;
   assign e_next   = CNTW'(eidx_ff) + 1'b1;
   assign p_next   = CNTW'(pidx_ff) + 1'b1;
   assign last_e   = !(e_next < n_e);
   assign last_p   = !(p_next < n_p);
   assign last_all = last_e && (eside_ff == SIDE_A);
   assign advance_edge = ((state_ff == ST_NORM) && nrsp.done && !nrsp.ok) ||
                         (state_ff == ST_BEST);

   // edge vector and its perpendicular
   assign cur_x     = rdata_ff[63:32];
   assign cur_y     = rdata_ff[31:0];
   assign ex        = 33'(cur_x) - 33'(vp_x_ff);
   assign ey        = 33'(cur_y) - 33'(vp_y_ff);
   assign nreq.start = (state_ff == ST_EDGE_D);
   assign nreq.dx   = -34'(ey);
   assign nreq.dy   = 34'(ex);

   // bounding-box sums (twice the center)
   assign sum_ax = 33'(a_min_x_ff) + 33'(a_max_x_ff);
   assign sum_ay = 33'(a_min_y_ff) + 33'(a_max_y_ff);
   assign sum_bx = 33'(b_min_x_ff) + 33'(b_max_x_ff);
   assign sum_by = 33'(b_min_y_ff) + 33'(b_max_y_ff);

   assign ov16    = best_ff[63:30];
   assign abs_bax = bax_ff[31] ? 32'(-bax_ff) : 32'(bax_ff);
   assign abs_bay = bay_ff[31] ? 32'(-bay_ff) : 32'(bay_ff);
   assign neg_x   = bax_ff[31] != !pos_ff;
   assign neg_y   = bay_ff[31] != !pos_ff;

   // shared multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_PROJ_X: begin op_a = 35'(cur_x); op_b = nrsp.ax; end
         ST_PROJ_Y: begin op_a = 35'(cur_y); op_b = nrsp.ay; end
         ST_CTR_AX: begin op_a = 35'(sum_ax); op_b = bax_ff; end
         ST_CTR_AY: begin op_a = 35'(sum_ay); op_b = bay_ff; end
         ST_CTR_BX: begin op_a = 35'(sum_bx); op_b = bax_ff; end
         ST_CTR_BY: begin op_a = 35'(sum_by); op_b = bay_ff; end
         ST_PUSH_X: begin op_a = $signed({1'b0, ov16}); op_b = $signed(abs_bax); end
         ST_PUSH_Y: begin op_a = $signed({1'b0, ov16}); op_b = $signed(abs_bay); end
         default: ;
      endcase
   end
   assign prod    = op_a * op_b;
   assign acc_sum = acc_ff + mul_ff;
   assign dot     = 64'(acc_sum);

   // interval overlap on the current axis
   always_comb begin
      sep_in = 1'b0;
      ov_in  = '0;
      if (bl_ff < al_ff && al_ff < bh_ff) ov_in = 64'(bh_ff - al_ff);
      else if (bl_ff < ah_ff && ah_ff < bh_ff) ov_in = 64'(ah_ff - bl_ff);
      else if (al_ff < bl_ff && bl_ff < ah_ff) ov_in = 64'(bh_ff - bl_ff);
      else sep_in = 1'b1;
   end
   assign best_upd = !found_ff || (ov_ff < best_ff);

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // next state and memory read address
   always_comb begin
      state_in = state_ff;
      raddr    = pidx_ff;
      rside    = pside_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req.command == CMD_EVAL)
               state_in = short_cnt ? ST_FINISH : ST_EDGE_P;
         end
         ST_EDGE_P: begin
            raddr    = prev_idx;
            rside    = eside_ff;
            state_in = ST_EDGE_I;
         end
         ST_EDGE_I: begin
            raddr    = eidx_ff;
            rside    = eside_ff;
            state_in = ST_EDGE_D;
         end
         ST_EDGE_D: state_in = ST_NORM;
         ST_NORM: begin
            if (nrsp.done) begin
               if (nrsp.ok) state_in = ST_PROJ_RD;
               else if (last_all) state_in = found_ff ? ST_CTR_AX : ST_FINISH;
               else state_in = ST_EDGE_P;
            end
         end
         ST_PROJ_RD: state_in = ST_PROJ_X;
         ST_PROJ_X:  state_in = ST_PROJ_Y;
         ST_PROJ_Y:  state_in = ST_PROJ_S;
         ST_PROJ_S: begin
            if (!last_p || pside_ff == SIDE_A) state_in = ST_PROJ_RD;
            else state_in = ST_OVL;
         end
         ST_OVL:    state_in = sep_in ? ST_FINISH : ST_BEST;
         ST_BEST:   state_in = last_all ? ST_CTR_AX : ST_EDGE_P;
         ST_CTR_AX: state_in = ST_CTR_AY;
         ST_CTR_AY: state_in = ST_CTR_AS;
         ST_CTR_AS: state_in = ST_CTR_BX;
         ST_CTR_BX: state_in = ST_CTR_BY;
         ST_CTR_BY: state_in = ST_CTR_BS;
         ST_CTR_BS: state_in = ST_PUSH_X;
         ST_PUSH_X: state_in = ST_PUSH_Y;
         ST_PUSH_Y: state_in = ST_PUSH_S;
         ST_PUSH_S: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // vertex memories
   always_ff @(posedge clock) begin
      if (req_fire && req.command == CMD_ADD_A && count_a_ff < MAXC)
         mem_a[count_a_ff[IDXW-1:0]] <= {req.vertex_x, req.vertex_y};
      if (req_fire && req.command == CMD_ADD_B && count_b_ff < MAXC)
         mem_b[count_b_ff[IDXW-1:0]] <= {req.vertex_x, req.vertex_y};
      rdata_ff <= (rside == SIDE_B) ? mem_b[raddr] : mem_a[raddr];
   end

   // counts, drop flag and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire && req.command == CMD_ADD_A) begin
            if (count_a_ff < MAXC) count_a_ff <= count_a_ff + 1'b1;
            else dropped_ff <= 1'b1;
         end
         if (req_fire && req.command == CMD_ADD_B) begin
            if (count_b_ff < MAXC) count_b_ff <= count_b_ff + 1'b1;
            else dropped_ff <= 1'b1;
         end
         if (state_ff == ST_FINISH && rsp_free) begin
            count_a_ff   <= '0;
            count_b_ff   <= '0;
            dropped_ff   <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // bounding box update on kept vertices
   always_ff @(posedge clock) begin
      if (req_fire && req.command == CMD_ADD_A && count_a_ff < MAXC) begin
         if (count_a_ff == '0) begin
            a_min_x_ff <= req.vertex_x; a_max_x_ff <= req.vertex_x;
            a_min_y_ff <= req.vertex_y; a_max_y_ff <= req.vertex_y;
         end else begin
            if (req.vertex_x < a_min_x_ff) a_min_x_ff <= req.vertex_x;
            if (req.vertex_x > a_max_x_ff) a_max_x_ff <= req.vertex_x;
            if (req.vertex_y < a_min_y_ff) a_min_y_ff <= req.vertex_y;
            if (req.vertex_y > a_max_y_ff) a_max_y_ff <= req.vertex_y;
         end
      end
      if (req_fire && req.command == CMD_ADD_B && count_b_ff < MAXC) begin
         if (count_b_ff == '0) begin
            b_min_x_ff <= req.vertex_x; b_max_x_ff <= req.vertex_x;
            b_min_y_ff <= req.vertex_y; b_max_y_ff <= req.vertex_y;
         end else begin
            if (req.vertex_x < b_min_x_ff) b_min_x_ff <= req.vertex_x;
            if (req.vertex_x > b_max_x_ff) b_max_x_ff <= req.vertex_x;
            if (req.vertex_y < b_min_y_ff) b_min_y_ff <= req.vertex_y;
            if (req.vertex_y > b_max_y_ff) b_max_y_ff <= req.vertex_y;
         end
      end
   end

   // evaluation datapath
   always_ff @(posedge clock) begin
      mul_ff <= prod;
      if (advance_edge) begin
         if (last_e) begin
            eside_ff <= SIDE_A;
            eidx_ff  <= '0;
         end else begin
            eidx_ff <= eidx_ff + 1'b1;
         end
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req.command == CMD_EVAL) begin
               eside_ff    <= SIDE_B;
               eidx_ff     <= '0;
               found_ff    <= 1'b0;
               res_coll_ff <= 1'b0;
               res_px_ff   <= '0;
               res_py_ff   <= '0;
               if (short_cnt) res_stat_ff <= STAT_SHORT;
               else if (dropped_ff) res_stat_ff <= STAT_DROP;
               else res_stat_ff <= STAT_OK;
            end
         end
         ST_EDGE_I: begin
            vp_x_ff <= cur_x;
            vp_y_ff <= cur_y;
         end
         ST_NORM: begin
            if (nrsp.done && nrsp.ok) begin
               pside_ff <= SIDE_A;
               pidx_ff  <= '0;
            end
         end
         ST_PROJ_Y: acc_ff <= mul_ff;
         ST_PROJ_S: begin
            if (pside_ff == SIDE_A) begin
               if (pidx_ff == '0 || dot < al_ff) al_ff <= dot;
               if (pidx_ff == '0 || dot > ah_ff) ah_ff <= dot;
            end else begin
               if (pidx_ff == '0 || dot < bl_ff) bl_ff <= dot;
               if (pidx_ff == '0 || dot > bh_ff) bh_ff <= dot;
            end
            if (last_p) begin
               pidx_ff  <= '0;
               pside_ff <= SIDE_B;
            end else begin
               pidx_ff <= pidx_ff + 1'b1;
            end
         end
         ST_OVL: ov_ff <= ov_in;
         ST_BEST: begin
            if (best_upd) begin
               found_ff <= 1'b1;
               best_ff  <= ov_ff;
               bax_ff   <= nrsp.ax;
               bay_ff   <= nrsp.ay;
            end
         end
         ST_CTR_AY: acc_ff <= mul_ff;
         ST_CTR_AS: ca_ff  <= acc_sum;
         ST_CTR_BY: acc_ff <= mul_ff;
         ST_CTR_BS: pos_ff <= ca_ff > acc_sum;
         ST_PUSH_Y: res_px_ff <= push_sat(mul_ff[64:30], neg_x);
         ST_PUSH_S: begin
            res_py_ff   <= push_sat(mul_ff[64:30], neg_y);
            res_coll_ff <= 1'b1;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_coll_ff <= res_coll_ff;
               rsp_px_ff   <= res_px_ff;
               rsp_py_ff   <= res_py_ff;
               rsp_stat_ff <= res_stat_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.colliding = rsp_coll_ff;
   assign rsp.push_x    = rsp_px_ff;
   assign rsp.push_y    = rsp_py_ff;
   assign rsp.status    = rsp_stat_ff;

   // checks
   `CPSAT_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_a_ff <= MAXC && count_b_ff <= MAXC, "vertex count above capacity")
   `CPSAT_ASSERT_NXT(a_eval_busy, clock, reset, req.valid && req.ready && req.command == CMD_EVAL, !req.ready, "input taken right after evaluate")
   `CPSAT_ASSERT_IMP(a_sep_zero, clock, reset, rsp.valid && !rsp.colliding, rsp.push_x == '0 && rsp.push_y == '0, "nonzero push without collision")
   `CPSAT_ASSERT_IMP(a_short_nocoll, clock, reset, rsp.valid && rsp.status == STAT_SHORT, !rsp.colliding, "collision reported on short polygon")

endmodule
